// ===== rtl/core/led_scanner_fade_defines.svh =====
// Assertion macros shared by the scanner RTL.
// Needs i_clk and i_rst_n in the scope where a macro is used.
`ifndef LED_SCANNER_FADE_DEFINES_SVH
`define LED_SCANNER_FADE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LSF_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("scanner check failed");

// The consequent must hold in the cycle after the antecedent.
`define LSF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("scanner check failed");

`endif

// ===== rtl/core/lsf_pkg.sv =====
// Shared types and constants for the LED scanner with fading trail.
// No dependencies.
package lsf_pkg;

    localparam int NUM_LEDS_DEF = 16;
    localparam int PIX_IDX_W    = 6;
    localparam int COLOR_W      = 8;
    localparam int CNT_W        = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int S_TDATA_W    = 8;
    localparam int M_TDATA_W    = 32;

    localparam logic [COLOR_W-1:0] EYE_RED_RST   = 8'hFF;
    localparam logic [COLOR_W-1:0] EYE_GREEN_RST = 8'h00;
    localparam logic [COLOR_W-1:0] EYE_BLUE_RST  = 8'h00;
    localparam logic [CNT_W-1:0]   INTERVAL_RST  = 16'd50;
    localparam logic [CNT_W-1:0]   CNT_MAX       = 16'hFFFF;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } t_rgb;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EYE_RED   = 2'd0,
        CFG_EYE_GREEN = 2'd1,
        CFG_EYE_BLUE  = 2'd2,
        CFG_INTERVAL  = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CALC,
        S_SEND
    } t_state;

endpackage

// ===== rtl/core/lsf_pixel_mem.sv =====
// Pixel colour store: one entry per LED, registered read, valid bit per entry.
// Depends on lsf_pkg.
module lsf_pixel_mem
    import lsf_pkg::*;
#(
    parameter int NUM_LEDS = NUM_LEDS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_rd_en,
    input  logic [$clog2(NUM_LEDS)-1:0] i_rd_addr,
    input  logic                        i_wr_en,
    input  logic [$clog2(NUM_LEDS)-1:0] i_wr_addr,
    input  t_rgb                        i_wr_data,
    output t_rgb                        o_rd_data
);

    t_rgb                r_mem [NUM_LEDS];
    logic [NUM_LEDS-1:0] r_valid;
    t_rgb                r_rd_data;
    logic                r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    // An entry never written since reset reads as black.
    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

// ===== rtl/core/lsf_pixel_alu.sv =====
// Shared pixel unit: decides whether a pixel is lit by the eye and halves it otherwise.
// Depends on lsf_pkg.
module lsf_pixel_alu
    import lsf_pkg::*;
#(
    parameter int NUM_LEDS = NUM_LEDS_DEF
) (
    input  logic [$clog2(NUM_LEDS)-1:0]       i_idx,
    input  logic [$clog2(2*(NUM_LEDS-1))-1:0] i_pos,
    input  logic [$clog2(2*NUM_LEDS-1)-1:0]   i_mirror,
    input  t_rgb                              i_eye,
    input  t_rgb                              i_old,
    output t_rgb                              o_new
);

    localparam int CMP_W = $clog2(2*NUM_LEDS-1);

    logic [CMP_W-1:0] idx_ext;
    logic [CMP_W-1:0] pos_ext;
    logic             lit;

    assign idx_ext = CMP_W'(i_idx);
    assign pos_ext = CMP_W'(i_pos);
    assign lit     = (idx_ext == pos_ext) || (idx_ext == i_mirror);

    always_comb begin
        if (lit) begin
            o_new = i_eye;
        end else begin
            o_new.red   = i_old.red   >> 1;
            o_new.green = i_old.green >> 1;
            o_new.blue  = i_old.blue  >> 1;
        end
    end

endmodule

// ===== rtl/core/led_scanner_fade.sv =====
// A back-and-forth scanner eye with a fading trail. Each input item is one millisecond
// tick; an item with the tick bit clear or one that does not complete the frame interval
// gives no output. An item that completes the interval renders a frame of NUM_LEDS
// output items, pixel 0 first and the last marked with tlast; each pixel goes through a
// store read, the pixel update and write-back, and the output handover, which waits
// while the output is held off. The pace is set by the single pixel unit and the colour
// store it updates in place, whose read and write ports both take the pixel index.
// Input ready is low while a frame is being rendered. The store needs no clearing pass
// after reset. Configuration writes are taken at any time but are meant for idle.
module led_scanner_fade
    import lsf_pkg::*;
#(
    parameter int NUM_LEDS = NUM_LEDS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [S_TDATA_W-1:0]  i_s_tdata,   // [0] tick, [7:1] zero
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [M_TDATA_W-1:0]  o_m_tdata,   // [5:0] pixel_index, [13:6] pix_red,
                                               // [21:14] pix_green, [29:22] pix_blue
    output logic                  o_m_tlast,   // last_pixel
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

`include "led_scanner_fade_defines.svh"

    localparam int IDX_W    = $clog2(NUM_LEDS);
    localparam int POS_W    = $clog2(2*(NUM_LEDS-1));
    localparam int MIR_W    = $clog2(2*NUM_LEDS-1);
    localparam int TRIP_LEN = 2*(NUM_LEDS-1);

    t_rgb                  r_eye;
    logic [CNT_W-1:0]      r_interval;

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_elapsed, n_elapsed;
    logic [POS_W-1:0]      r_pos, n_pos;
    logic [MIR_W-1:0]      r_mirror, n_mirror;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic                  r_out_valid, n_out_valid;
    logic [PIX_IDX_W-1:0]  r_out_idx, n_out_idx;
    t_rgb                  r_out_rgb, n_out_rgb;
    logic                  r_out_last, n_out_last;

    logic                  in_acc;
    logic                  tick;
    logic [CNT_W-1:0]      cnt_inc;
    logic                  fire;
    logic                  idx_last;
    logic                  rd_en;
    logic                  wr_en;
    t_rgb                  old_rgb;
    t_rgb                  new_rgb;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eye.red   <= EYE_RED_RST;
            r_eye.green <= EYE_GREEN_RST;
            r_eye.blue  <= EYE_BLUE_RST;
            r_interval  <= INTERVAL_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_EYE_RED:   r_eye.red   <= i_cfg_data[COLOR_W-1:0];
                CFG_EYE_GREEN: r_eye.green <= i_cfg_data[COLOR_W-1:0];
                CFG_EYE_BLUE:  r_eye.blue  <= i_cfg_data[COLOR_W-1:0];
                CFG_INTERVAL:  r_interval  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign in_acc   = i_s_tvalid && o_s_tready;
    assign tick     = i_s_tdata[0];
    assign cnt_inc  = (r_elapsed == CNT_MAX) ? r_elapsed : r_elapsed + CNT_W'(1);
    assign fire     = cnt_inc >= r_interval;
    assign idx_last = r_idx == IDX_W'(NUM_LEDS-1);
    assign rd_en    = r_state == S_READ;
    assign wr_en    = r_state == S_CALC;

    lsf_pixel_mem #(
        .NUM_LEDS (NUM_LEDS)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_idx),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_idx),
        .i_wr_data (new_rgb),
        .o_rd_data (old_rgb)
    );

    lsf_pixel_alu #(
        .NUM_LEDS (NUM_LEDS)
    ) u_alu (
        .i_idx    (r_idx),
        .i_pos    (r_pos),
        .i_mirror (r_mirror),
        .i_eye    (r_eye),
        .i_old    (old_rgb),
        .o_new    (new_rgb)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_elapsed   <= '0;
            r_pos       <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_elapsed   <= n_elapsed;
            r_pos       <= n_pos;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mirror   <= n_mirror;
        r_out_idx  <= n_out_idx;
        r_out_rgb  <= n_out_rgb;
        r_out_last <= n_out_last;
    end

    always_comb begin
        n_state     = r_state;
        n_elapsed   = r_elapsed;
        n_pos       = r_pos;
        n_mirror    = r_mirror;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        n_out_idx   = r_out_idx;
        n_out_rgb   = r_out_rgb;
        n_out_last  = r_out_last;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && tick) begin
                    if (fire) begin
                        n_elapsed = '0;
                        n_idx     = '0;
                        n_mirror  = MIR_W'(TRIP_LEN) - MIR_W'(r_pos);
                        n_state   = S_READ;
                    end else begin
                        n_elapsed = cnt_inc;
                    end
                end
            end
            S_READ: begin
                n_state = S_CALC;
            end
            S_CALC: begin
                n_out_valid = 1'b1;
                n_out_idx   = PIX_IDX_W'(r_idx);
                n_out_rgb   = new_rgb;
                n_out_last  = idx_last;
                n_state     = S_SEND;
            end
            S_SEND: begin
                if (i_m_tready) begin
                    n_out_valid = 1'b0;
                    if (idx_last) begin
                        n_pos   = (r_pos == POS_W'(TRIP_LEN-1)) ? '0 : r_pos + POS_W'(1);
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + IDX_W'(1);
                        n_state = S_READ;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_s_tready = r_state == S_IDLE;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_out_rgb.blue, r_out_rgb.green, r_out_rgb.red, r_out_idx};
    assign o_m_tlast  = r_out_last;

    `LSF_ASSERT_SAME(a_ready_out_empty, o_s_tready, !o_m_tvalid)
    `LSF_ASSERT_SAME(a_last_on_final, o_m_tvalid && o_m_tlast,
        r_out_idx == PIX_IDX_W'(NUM_LEDS-1))
    `LSF_ASSERT_SAME(a_pos_in_trip, 1'b1, MIR_W'(r_pos) < MIR_W'(TRIP_LEN))
    `LSF_ASSERT_NEXT(a_frame_clears_count, in_acc && tick && fire,
        r_elapsed == '0 && r_state == S_READ)

endmodule
